>>> hdl/gotr_pkg.sv
// Shared types and constants of the gravity orientation tracker.
`timescale 1ns / 1ps

package gotr_pkg;

   // shared multiplier: operand B width and the chunk width taken from operand A per pass
   localparam int MUL_CHUNK_BITS = 32;
   localparam int MUL_B_BITS     = 31;

   // fixed-point formats
   localparam int ALPHA_FRAC_BITS = 16;
   localparam int RATIO_FRAC_BITS = 8;
   localparam int RES_BITS_MAX    = 29;
   localparam int GZ_RESET_Q79    = -5023;

   // csr port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LP_ALPHA        = 3'd0,
      CSR_RAISED_RATIO    = 3'd1,
      CSR_DOMINANCE_RATIO = 3'd2,
      CSR_ENTER_DWELL     = 3'd3,
      CSR_LEAVE_DWELL     = 3'd4,
      CSR_ACT_THRESHOLD   = 3'd5,
      CSR_ACT_DWELL       = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ORIENT_NEUTRAL = 2'd0,
      ORIENT_FLAT    = 2'd1,
      ORIENT_RAISED  = 2'd2
   } orient_type;

   typedef struct packed {
      logic [15:0] lp_alpha;
      logic [11:0] raised_ratio;
      logic [11:0] dominance_ratio;
      logic [7:0]  enter_dwell;
      logic [7:0]  leave_dwell;
      logic [14:0] activity_threshold;
      logic [9:0]  activity_dwell;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      lp_alpha:           16'd656,
      raised_ratio:       12'd256,
      dominance_ratio:    12'd384,
      enter_dwell:        8'd10,
      leave_dwell:        8'd30,
      activity_threshold: 15'd1024,
      activity_dwell:     10'd50
   };

   // multiplier handshake toward the sequencer
   typedef struct packed {
      logic ready;
      logic done;
   } mul_status_type;

endpackage

>>> hdl/gotr_req_if.sv
// Sample input channel: valid/ready plus one three-axis accelerometer item.
`timescale 1ns / 1ps

interface gotr_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] accel_x;
   logic signed [SAMPLE_BITS-1:0] accel_y;
   logic signed [SAMPLE_BITS-1:0] accel_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
   modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

>>> hdl/gotr_rsp_if.sv
// Result channel: valid/ready plus filtered gravity, orientation and activity status.
`timescale 1ns / 1ps

interface gotr_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] grav_x;
   logic signed [SAMPLE_BITS-1:0] grav_y;
   logic signed [SAMPLE_BITS-1:0] grav_z;
   logic [1:0]                    orientation;
   logic                          orientation_changed;
   logic                          motion_now;
   logic [9:0]                    quiet_samples;
   logic                          seeded_now;

   modport source (output valid, output grav_x, output grav_y, output grav_z,
                   output orientation, output orientation_changed, output motion_now,
                   output quiet_samples, output seeded_now, input ready);
   modport sink   (input valid, input grav_x, input grav_y, input grav_z,
                   input orientation, input orientation_changed, input motion_now,
                   input quiet_samples, input seeded_now, output ready);
endinterface

>>> hdl/gotr_csr_if.sv
// Register write channel: valid/ready, register index and write data.
`timescale 1ns / 1ps

interface gotr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [gotr_pkg::CSR_INDEX_BITS-1:0] index;
   logic [gotr_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/gravity_orientation_tracker_unit.sv
// Top level: gravity low-pass filter, orientation dwell and motion detector.
// Ten products go through one shared multiplier, one issue per cycle while it is ready;
// products after the threshold square wait until the three filter products retire, and
// operand A takes more than one chunk pass when SAMPLE_BITS+FILTER_FRAC_BITS exceeds 32.
// A seeding sample skips the multiplier and goes straight to finish. One sample at a time.
// Synchronous reset restores register defaults and an unseeded filter; no clearing pass.
`timescale 1ns / 1ps

module gravity_orientation_tracker_unit #(
   parameter int SAMPLE_BITS      = 16,
   parameter int FILTER_FRAC_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   gotr_csr_if.sink   csr_if,
   gotr_req_if.sink   req_if,
   gotr_rsp_if.source rsp_if
);

   localparam int SB        = SAMPLE_BITS;
   localparam int FB        = FILTER_FRAC_BITS;
   localparam int EW        = SB + FB;
   localparam int RES_SHIFT = (EW > gotr_pkg::RES_BITS_MAX) ? EW - gotr_pkg::RES_BITS_MAX : 0;
   localparam int MB        = gotr_pkg::MUL_B_BITS;
   localparam int MA        = (EW > MB) ? EW : MB;
   localparam int CW        = gotr_pkg::MUL_CHUNK_BITS;
   localparam int PW        = ((MA + CW - 1) / CW) * CW + MB;
   localparam int SUMW      = PW + 2;
   localparam int FW        = EW + gotr_pkg::ALPHA_FRAC_BITS + 2;

   localparam logic signed [EW:0]   HALF   = (EW+1)'((1 << FB) >> 1);
   localparam logic signed [SB:0]   SMAX   = (SB+1)'((longint'(1) << (SB - 1)) - 1);
   localparam logic signed [SB:0]   SMIN   = (SB+1)'(-(longint'(1) << (SB - 1)));
   localparam logic signed [FW-1:0] FROUND = FW'(1 << (gotr_pkg::ALPHA_FRAC_BITS - 1));
   localparam logic signed [EW-1:0] EST_Z_RESET =
      EW'(longint'(gotr_pkg::GZ_RESET_Q79) * (longint'(1) << FB));

   // operation sequence of one filtered sample
   localparam logic [3:0] OP_FILT_X   = 4'd0;
   localparam logic [3:0] OP_FILT_Y   = 4'd1;
   localparam logic [3:0] OP_FILT_Z   = 4'd2;
   localparam logic [3:0] OP_THR_SQ   = 4'd3;
   localparam logic [3:0] OP_RAISED   = 4'd4;
   localparam logic [3:0] OP_FLAT_X   = 4'd5;
   localparam logic [3:0] OP_FLAT_Y   = 4'd6;
   localparam logic [3:0] OP_RES_X    = 4'd7;
   localparam logic [3:0] OP_RES_Y    = 4'd8;
   localparam logic [3:0] OP_RES_Z    = 4'd9;
   localparam logic [3:0] OP_COUNT    = 4'd10;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_FIN
   } state_type;

   gotr_pkg::cfg_type        cfg;
   gotr_pkg::mul_status_type mul_stat;
   logic                     mul_start;
   logic [MA-1:0]            mul_a;
   logic [MB-1:0]            mul_b;
   logic [PW-1:0]            mul_product;

   state_type               state_ff, state_in;
   logic signed [SB-1:0]    smp_ff [3];
   logic signed [SB-1:0]    smp_in [3];
   logic signed [EW-1:0]    est_ff [3];
   logic signed [EW-1:0]    est_in [3];
   logic                    seeded_ff, seeded_in;
   logic                    seed_ff, seed_in;
   logic [3:0]              ic_ff, ic_in;
   logic [3:0]              rc_ff, rc_in;
   logic [PW-1:0]           thrsq_ff, thrsq_in;
   logic [SUMW-1:0]         sum_ff, sum_in;
   logic                    big_r_ff, big_r_in;
   logic                    flat_a_ff, flat_a_in;
   logic                    flat_b_ff, flat_b_in;
   gotr_pkg::orient_type    cand_ff, cand_in;
   logic [7:0]              hold_ff, hold_in;
   gotr_pkg::orient_type    commit_ff, commit_in;
   logic [9:0]              quiet_ff, quiet_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0]    grav_ff [3];
   logic signed [SB-1:0]    grav_in [3];
   logic                    changed_ff, changed_in;
   logic                    motion_ff, motion_in;
   logic                    rsp_seed_ff, rsp_seed_in;

   // per-axis helpers
   logic signed [EW-1:0]    smp_ext [3];
   logic signed [EW-1:0]    req_ext [3];
   logic signed [EW:0]      diff [3];
   logic                    diff_neg [3];
   logic [EW-1:0]           abs_d [3];
   logic [EW-1:0]           abs_g [3];
   logic signed [EW:0]      rnd [3];
   logic signed [SB:0]      rnd_q [3];
   logic signed [SB-1:0]    grav_sat [3];
   logic [MB-1:0]           thr_val;

   // retire helpers
   logic                    filt_neg;
   logic signed [EW-1:0]    filt_est;
   logic signed [FW-1:0]    filt_mag;
   logic signed [FW-1:0]    filt_sp;
   logic signed [FW-1:0]    filt_upd;
   logic signed [EW-1:0]    filt_new;
   logic [PW-1:0]           gx_scaled;
   logic [PW-1:0]           gz_scaled;

   // finish helpers
   logic                    out_free;
   logic                    gx_pos;
   logic                    gz_pos;
   gotr_pkg::orient_type    cls;
   logic [7:0]              need;
   logic                    issue_ok;

   gotr_cfg u_cfg (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   gotr_mul #(
      .A_BITS (MA),
      .B_BITS (MB)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .status  (mul_stat),
      .product (mul_product)
   );

   // axis differences, magnitudes and output rounding
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         smp_ext[i]  = EW'(smp_ff[i]) <<< FB;
         diff[i]     = (EW+1)'(smp_ext[i]) - (EW+1)'(est_ff[i]);
         diff_neg[i] = diff[i][EW];
         abs_d[i]    = diff_neg[i] ? EW'(-diff[i]) : EW'(diff[i]);
         abs_g[i]    = est_ff[i][EW-1] ? EW'(-est_ff[i]) : EW'(est_ff[i]);
         rnd[i]      = (EW+1)'(est_ff[i]) + HALF;
         rnd_q[i]    = (SB+1)'(rnd[i] >>> FB);
         if (rnd_q[i] > SMAX) begin
            grav_sat[i] = SB'(SMAX);
         end else if (rnd_q[i] < SMIN) begin
            grav_sat[i] = SB'(SMIN);
         end else begin
            grav_sat[i] = SB'(rnd_q[i]);
         end
      end
      req_ext[0] = EW'(req_if.accel_x) <<< FB;
      req_ext[1] = EW'(req_if.accel_y) <<< FB;
      req_ext[2] = EW'(req_if.accel_z) <<< FB;
      thr_val    = MB'((MB'(cfg.activity_threshold) << FB) >> RES_SHIFT);
   end

   // operand select for the next product
   always_comb begin
      issue_ok  = (ic_ff < OP_COUNT) && ((ic_ff <= OP_THR_SQ) || (rc_ff > OP_FILT_Z));
      mul_start = (state_ff == S_RUN) && mul_stat.ready && issue_ok;
      case (ic_ff)
         OP_FILT_X: begin
            mul_a = MA'(abs_d[0]);
            mul_b = MB'(cfg.lp_alpha);
         end
         OP_FILT_Y: begin
            mul_a = MA'(abs_d[1]);
            mul_b = MB'(cfg.lp_alpha);
         end
         OP_FILT_Z: begin
            mul_a = MA'(abs_d[2]);
            mul_b = MB'(cfg.lp_alpha);
         end
         OP_THR_SQ: begin
            mul_a = MA'(thr_val);
            mul_b = thr_val;
         end
         OP_RAISED: begin
            mul_a = MA'(abs_g[2]);
            mul_b = MB'(cfg.raised_ratio);
         end
         OP_FLAT_X: begin
            mul_a = MA'(abs_g[0]);
            mul_b = MB'(cfg.dominance_ratio);
         end
         OP_FLAT_Y: begin
            mul_a = MA'(abs_g[1]);
            mul_b = MB'(cfg.dominance_ratio);
         end
         OP_RES_X: begin
            mul_a = MA'(abs_d[0] >> RES_SHIFT);
            mul_b = MB'(abs_d[0] >> RES_SHIFT);
         end
         OP_RES_Y: begin
            mul_a = MA'(abs_d[1] >> RES_SHIFT);
            mul_b = MB'(abs_d[1] >> RES_SHIFT);
         end
         OP_RES_Z: begin
            mul_a = MA'(abs_d[2] >> RES_SHIFT);
            mul_b = MB'(abs_d[2] >> RES_SHIFT);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // filter step: est += round(alpha * d / 2^16), floor after adding half
   always_comb begin
      case (rc_ff)
         OP_FILT_X: begin
            filt_neg = diff_neg[0];
            filt_est = est_ff[0];
         end
         OP_FILT_Y: begin
            filt_neg = diff_neg[1];
            filt_est = est_ff[1];
         end
         default: begin
            filt_neg = diff_neg[2];
            filt_est = est_ff[2];
         end
      endcase
      filt_mag  = $signed(FW'(mul_product[EW+gotr_pkg::ALPHA_FRAC_BITS-1:0]));
      filt_sp   = filt_neg ? -filt_mag : filt_mag;
      filt_upd  = (filt_sp + FROUND) >>> gotr_pkg::ALPHA_FRAC_BITS;
      filt_new  = filt_est + EW'(filt_upd);
      gx_scaled = PW'($unsigned(est_ff[0])) << gotr_pkg::RATIO_FRAC_BITS;
      gz_scaled = PW'($unsigned(est_ff[2])) << gotr_pkg::RATIO_FRAC_BITS;
   end

   // classification of the updated estimate and result slot check
   always_comb begin
      gx_pos = !est_ff[0][EW-1] && (est_ff[0] != '0);
      gz_pos = !est_ff[2][EW-1] && (est_ff[2] != '0);
      if (gx_pos && big_r_ff) begin
         cls = gotr_pkg::ORIENT_RAISED;
      end else if (gz_pos && flat_a_ff && flat_b_ff) begin
         cls = gotr_pkg::ORIENT_FLAT;
      end else begin
         cls = gotr_pkg::ORIENT_NEUTRAL;
      end
      out_free = !rsp_valid_ff || rsp_if.ready;
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      smp_in       = smp_ff;
      est_in       = est_ff;
      seeded_in    = seeded_ff;
      seed_in      = seed_ff;
      ic_in        = ic_ff;
      rc_in        = rc_ff;
      thrsq_in     = thrsq_ff;
      sum_in       = sum_ff;
      big_r_in     = big_r_ff;
      flat_a_in    = flat_a_ff;
      flat_b_in    = flat_b_ff;
      cand_in      = cand_ff;
      hold_in      = hold_ff;
      commit_in    = commit_ff;
      quiet_in     = quiet_ff;
      grav_in      = grav_ff;
      changed_in   = changed_ff;
      motion_in    = motion_ff;
      rsp_seed_in  = rsp_seed_ff;
      need         = cfg.leave_dwell;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               smp_in[0] = req_if.accel_x;
               smp_in[1] = req_if.accel_y;
               smp_in[2] = req_if.accel_z;
               ic_in     = OP_FILT_X;
               rc_in     = OP_FILT_X;
               sum_in    = '0;
               seed_in   = !seeded_ff;
               if (!seeded_ff) begin
                  // first sample only seeds the estimate
                  est_in    = req_ext;
                  seeded_in = 1'b1;
                  state_in  = S_FIN;
               end else begin
                  state_in = S_RUN;
               end
            end
         end

         S_RUN: begin
            if (mul_start) begin
               ic_in = ic_ff + 4'd1;
            end
            // retire products in issue order
            if (mul_stat.done) begin
               rc_in = rc_ff + 4'd1;
               case (rc_ff)
                  OP_FILT_X: est_in[0] = filt_new;
                  OP_FILT_Y: est_in[1] = filt_new;
                  OP_FILT_Z: est_in[2] = filt_new;
                  OP_THR_SQ: thrsq_in  = mul_product;
                  OP_RAISED: big_r_in  = gx_scaled > mul_product;
                  OP_FLAT_X: flat_a_in = gz_scaled > mul_product;
                  OP_FLAT_Y: flat_b_in = gz_scaled > mul_product;
                  OP_RES_X, OP_RES_Y, OP_RES_Z: sum_in = sum_ff + SUMW'(mul_product);
                  default: rc_in = rc_ff;
               endcase
               if (rc_ff == OP_RES_Z) begin
                  state_in = S_FIN;
               end
            end
         end

         S_FIN: begin
            if (out_free) begin
               changed_in = 1'b0;
               motion_in  = 1'b0;
               if (!seed_ff) begin
                  // candidate dwell, hold count capped at leave_dwell
                  if (cls == cand_ff) begin
                     if (hold_ff < cfg.leave_dwell) begin
                        hold_in = hold_ff + 8'd1;
                     end
                  end else begin
                     cand_in = cls;
                     hold_in = 8'd1;
                  end
                  need = (cand_in == gotr_pkg::ORIENT_NEUTRAL) ? cfg.leave_dwell
                                                               : cfg.enter_dwell;
                  if (hold_in >= need && cand_in != commit_ff) begin
                     commit_in  = cand_in;
                     changed_in = 1'b1;
                  end
                  // squared residual against squared threshold
                  if (sum_ff > SUMW'(thrsq_ff)) begin
                     motion_in = 1'b1;
                     quiet_in  = '0;
                  end else if (quiet_ff < cfg.activity_dwell) begin
                     quiet_in = quiet_ff + 10'd1;
                  end
               end
               grav_in      = grav_sat;
               rsp_seed_in  = seed_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         est_ff[0]    <= '0;
         est_ff[1]    <= '0;
         est_ff[2]    <= EST_Z_RESET;
         seeded_ff    <= 1'b0;
         ic_ff        <= '0;
         rc_ff        <= '0;
         cand_ff      <= gotr_pkg::ORIENT_NEUTRAL;
         hold_ff      <= '0;
         commit_ff    <= gotr_pkg::ORIENT_NEUTRAL;
         quiet_ff     <= gotr_pkg::CFG_RESET.activity_dwell;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         est_ff       <= est_in;
         seeded_ff    <= seeded_in;
         ic_ff        <= ic_in;
         rc_ff        <= rc_in;
         cand_ff      <= cand_in;
         hold_ff      <= hold_in;
         commit_ff    <= commit_in;
         quiet_ff     <= quiet_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      smp_ff      <= smp_in;
      seed_ff     <= seed_in;
      thrsq_ff    <= thrsq_in;
      sum_ff      <= sum_in;
      big_r_ff    <= big_r_in;
      flat_a_ff   <= flat_a_in;
      flat_b_ff   <= flat_b_in;
      grav_ff     <= grav_in;
      changed_ff  <= changed_in;
      motion_ff   <= motion_in;
      rsp_seed_ff <= rsp_seed_in;
   end

   // channel ports
   assign req_if.ready               = (state_ff == S_IDLE);
   assign rsp_if.valid               = rsp_valid_ff;
   assign rsp_if.grav_x              = grav_ff[0];
   assign rsp_if.grav_y              = grav_ff[1];
   assign rsp_if.grav_z              = grav_ff[2];
   assign rsp_if.orientation         = commit_ff;
   assign rsp_if.orientation_changed = changed_ff;
   assign rsp_if.motion_now          = motion_ff;
   assign rsp_if.quiet_samples       = quiet_ff;
   assign rsp_if.seeded_now          = rsp_seed_ff;

`ifndef SYNTHESIS
   // products only come back while a sample is being worked on
   a_mul_done_in_run: assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> state_ff == S_RUN)
      else $error("multiplier result outside of run state");

   // retire never overtakes issue
   a_retire_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN |-> rc_ff <= ic_ff)
      else $error("product retired before issue");

   // a seeding result carries no orientation change and no motion
   a_seed_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_seed_ff |-> !changed_ff && !motion_ff)
      else $error("seeding result flags orientation change or motion");

   // a reported change always lands on the candidate orientation
   a_change_is_cand: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN && out_free ##1 changed_ff |-> commit_ff == cand_ff)
      else $error("committed orientation differs from candidate");
`endif

endmodule

>>> hdl/gotr_cfg.sv
// Configuration register file written through the csr channel.
`timescale 1ns / 1ps

module gotr_cfg (
   input  logic              clock,
   input  logic              reset,
   gotr_csr_if.sink          csr_if,
   output gotr_pkg::cfg_type cfg
);

   gotr_pkg::cfg_type cfg_ff;
   gotr_pkg::cfg_type cfg_in;

   // writes are always accepted
   assign csr_if.ready = 1'b1;

   // register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            gotr_pkg::CSR_LP_ALPHA:        cfg_in.lp_alpha           = csr_if.data[15:0];
            gotr_pkg::CSR_RAISED_RATIO:    cfg_in.raised_ratio       = csr_if.data[11:0];
            gotr_pkg::CSR_DOMINANCE_RATIO: cfg_in.dominance_ratio    = csr_if.data[11:0];
            gotr_pkg::CSR_ENTER_DWELL:     cfg_in.enter_dwell        = csr_if.data[7:0];
            gotr_pkg::CSR_LEAVE_DWELL:     cfg_in.leave_dwell        = csr_if.data[7:0];
            gotr_pkg::CSR_ACT_THRESHOLD:   cfg_in.activity_threshold = csr_if.data[14:0];
            gotr_pkg::CSR_ACT_DWELL:       cfg_in.activity_dwell     = csr_if.data[9:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= gotr_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/gotr_mul.sv
// Shared unsigned multiplier: operand A in 32-bit chunks, partial product registered.
`timescale 1ns / 1ps

module gotr_mul #(
   parameter int A_BITS = 31,
   parameter int B_BITS = 31
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [A_BITS-1:0]              a,
   input  logic [B_BITS-1:0]              b,
   output gotr_pkg::mul_status_type       status,
   output logic [((A_BITS+gotr_pkg::MUL_CHUNK_BITS-1)/gotr_pkg::MUL_CHUNK_BITS)
                 *gotr_pkg::MUL_CHUNK_BITS+B_BITS-1:0] product
);

   localparam int CW        = gotr_pkg::MUL_CHUNK_BITS;
   localparam int NC        = (A_BITS + CW - 1) / CW;
   localparam int APW       = NC * CW;
   localparam int PW        = APW + B_BITS;
   localparam int PART_BITS = B_BITS + CW;
   localparam int CNT_BITS  = (NC > 1) ? $clog2(NC) : 1;

   logic [APW-1:0]       a_ff, a_in;
   logic [B_BITS-1:0]    b_ff, b_in;
   logic [CNT_BITS-1:0]  rem_ff, rem_in;
   logic [PART_BITS-1:0] part_ff, part_in;
   logic                 part_vld_ff, part_vld_in;
   logic                 part_first_ff, part_first_in;
   logic                 part_last_ff, part_last_in;
   logic [PW-1:0]        acc_ff, acc_in;
   logic                 done_ff, done_in;

   logic [APW-1:0]       a_pad;
   logic [CW-1:0]        mul_a;
   logic [B_BITS-1:0]    mul_b;

   // stage 1: one chunk product per cycle, most significant chunk first
   always_comb begin
      a_pad         = APW'(a);
      mul_a         = start ? a_pad[APW-1 -: CW] : a_ff[APW-1 -: CW];
      mul_b         = start ? b : b_ff;
      part_in       = PART_BITS'(mul_b) * PART_BITS'(mul_a);
      a_in          = a_ff;
      b_in          = b_ff;
      rem_in        = rem_ff;
      part_vld_in   = 1'b0;
      part_first_in = 1'b0;
      part_last_in  = 1'b0;
      if (start) begin
         a_in          = a_pad << CW;
         b_in          = b;
         rem_in        = CNT_BITS'(NC - 1);
         part_vld_in   = 1'b1;
         part_first_in = 1'b1;
         part_last_in  = (NC == 1);
      end else if (rem_ff != '0) begin
         a_in         = a_ff << CW;
         rem_in       = rem_ff - CNT_BITS'(1);
         part_vld_in  = 1'b1;
         part_last_in = (rem_ff == CNT_BITS'(1));
      end
   end

   // stage 2: shift-accumulate
   always_comb begin
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (part_vld_ff) begin
         acc_in  = part_first_ff ? PW'(part_ff) : (acc_ff << CW) + PW'(part_ff);
         done_in = part_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff      <= '0;
         part_vld_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         rem_ff      <= rem_in;
         part_vld_ff <= part_vld_in;
         done_ff     <= done_in;
      end
      a_ff          <= a_in;
      b_ff          <= b_in;
      part_ff       <= part_in;
      part_first_ff <= part_first_in;
      part_last_ff  <= part_last_in;
      acc_ff        <= acc_in;
   end

   assign status.ready = (rem_ff == '0);
   assign status.done  = done_ff;
   assign product      = acc_ff;

endmodule

>>> dv/tb_gravity_orientation_tracker_unit.sv
// Self-checking testbench for the gravity orientation tracker: directed and random samples.
`timescale 1ns / 1ps

module tb_gravity_orientation_tracker_unit;
   import gotr_pkg::*;

   localparam int SAMPLE_BITS      = 16;
   localparam int FILTER_FRAC_BITS = 8;
   localparam longint EST_SCALE    = longint'(1) << FILTER_FRAC_BITS;
   localparam longint EST_HALF     = EST_SCALE / 2;
   localparam int G_Q79            = 5023;   // 9.81 m/s^2 in Q7.9
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } sample_t;

   typedef struct packed {
      logic signed [15:0] grav_x;
      logic signed [15:0] grav_y;
      logic signed [15:0] grav_z;
      orient_type         orientation;
      logic               changed;
      logic               motion;
      logic [9:0]         quiet;
      logic               seeded;
   } tracker_out_t;

   logic clock;
   logic reset;

   gotr_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_ch ();
   gotr_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_ch ();
   gotr_csr_if csr_ch ();

   gravity_orientation_tracker_unit #(
      .SAMPLE_BITS      (SAMPLE_BITS),
      .FILTER_FRAC_BITS (FILTER_FRAC_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_ch),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // predictor state, mirrors the block after reset
   cfg_type    tracker_cfg = CFG_RESET;
   longint     grav_est [3] = '{0, 0, longint'(GZ_RESET_Q79) * EST_SCALE};
   bit         filter_seeded = 1'b0;
   orient_type committed_orient = ORIENT_NEUTRAL;
   orient_type cand_orient = ORIENT_NEUTRAL;
   int unsigned cand_hold = 0;
   int unsigned quiet_cnt = CFG_RESET.activity_dwell;

   sample_t      sample_q [$];
   tracker_out_t predicted_track_q [$];

   int  items_pushed = 0;
   int  results_seen = 0;
   int  errors = 0;
   int  commit_count = 0;
   int  motion_count = 0;
   int  settings_used = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   bit  idle_on = 1'b1;
   bit  hold_armed = 1'b0;
   bit  rsp_hold = 1'b0;

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // one filter/classify/dwell/activity step on the predictor state
   function automatic tracker_out_t track_sample(sample_t smp);
      longint s [3];
      longint mag2;
      longint lim;
      longint r;
      longint o;
      logic signed [15:0] g [3];
      orient_type cls;
      int unsigned need;
      tracker_out_t res;
      res = '0;
      s[0] = longint'($signed(smp.x)) * EST_SCALE;
      s[1] = longint'($signed(smp.y)) * EST_SCALE;
      s[2] = longint'($signed(smp.z)) * EST_SCALE;
      if (!filter_seeded) begin
         // first sample after reset only loads the estimate
         for (int i = 0; i < 3; i++) grav_est[i] = s[i];
         filter_seeded = 1'b1;
         res.seeded = 1'b1;
      end else begin
         for (int i = 0; i < 3; i++)
            grav_est[i] += (longint'(tracker_cfg.lp_alpha) * (s[i] - grav_est[i]) + 32768)
                           >>> ALPHA_FRAC_BITS;

         // classification by Q4.8 dominance ratios
         if (grav_est[0] > 0 && grav_est[0] * 256 >
             longint'(tracker_cfg.raised_ratio) * magnitude(grav_est[2]))
            cls = ORIENT_RAISED;
         else if (grav_est[2] > 0 &&
                  grav_est[2] * 256 > longint'(tracker_cfg.dominance_ratio) *
                                      magnitude(grav_est[0]) &&
                  grav_est[2] * 256 > longint'(tracker_cfg.dominance_ratio) *
                                      magnitude(grav_est[1]))
            cls = ORIENT_FLAT;
         else
            cls = ORIENT_NEUTRAL;

         // candidate dwell, hold capped at leave dwell
         if (cls == cand_orient) begin
            if (cand_hold < tracker_cfg.leave_dwell) cand_hold++;
         end else begin
            cand_orient = cls;
            cand_hold = 1;
         end
         need = (cand_orient == ORIENT_NEUTRAL) ? tracker_cfg.leave_dwell
                                                : tracker_cfg.enter_dwell;
         if (cand_hold >= need && cand_orient != committed_orient) begin
            committed_orient = cand_orient;
            res.changed = 1'b1;
         end

         // squared residual against squared threshold
         mag2 = 0;
         for (int i = 0; i < 3; i++) begin
            r = magnitude(s[i] - grav_est[i]);
            mag2 += r * r;
         end
         lim = longint'(tracker_cfg.activity_threshold) << FILTER_FRAC_BITS;
         if (mag2 > lim * lim) begin
            res.motion = 1'b1;
            quiet_cnt = 0;
         end else if (quiet_cnt < tracker_cfg.activity_dwell) begin
            quiet_cnt++;
         end
      end

      // round half up to Q7.9 and saturate
      for (int i = 0; i < 3; i++) begin
         o = (grav_est[i] + EST_HALF) >>> FILTER_FRAC_BITS;
         if (o > 32767) o = 32767;
         if (o < -32768) o = -32768;
         g[i] = o[15:0];
      end
      res.grav_x = g[0];
      res.grav_y = g[1];
      res.grav_z = g[2];
      res.orientation = committed_orient;
      res.quiet = quiet_cnt[9:0];
      return res;
   endfunction

   task automatic check_field(string what, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
      end
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sample driver
   always @(posedge clock) begin : req_driver
      sample_t smp;
      bit free;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         free = !req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            smp.x = req_ch.accel_x;
            smp.y = req_ch.accel_y;
            smp.z = req_ch.accel_z;
            predicted_track_q.push_back(track_sample(smp));
            free = 1'b1;
         end
         if (free) begin
            if (send_gap == 0 && idle_on && $urandom_range(0, 5) == 0)
               send_gap = $urandom_range(1, 5);
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
               smp = sample_q.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.accel_x <= smp.x;
               req_ch.accel_y <= smp.y;
               req_ch.accel_z <= smp.z;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin : rsp_monitor
      tracker_out_t want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (predicted_track_q.size() == 0) begin
               errors++;
               $display("%0t: result with no sample pending, expected none, actual grav %0h %0h %0h",
                        $time, rsp_ch.grav_x, rsp_ch.grav_y, rsp_ch.grav_z);
            end else begin
               want = predicted_track_q.pop_front();
               check_field("grav_x", want.grav_x, rsp_ch.grav_x);
               check_field("grav_y", want.grav_y, rsp_ch.grav_y);
               check_field("grav_z", want.grav_z, rsp_ch.grav_z);
               check_field("orientation", want.orientation, rsp_ch.orientation);
               check_field("orientation_changed", want.changed, rsp_ch.orientation_changed);
               check_field("motion_now", want.motion, rsp_ch.motion_now);
               check_field("quiet_samples", want.quiet, rsp_ch.quiet_samples);
               check_field("seeded_now", want.seeded, rsp_ch.seeded_now);
               commit_count += want.changed;
               motion_count += want.motion;
            end
         end
         if (rsp_hold) begin
            rsp_ch.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 4);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // long result hold-off so the block backs up onto its input
   initial begin : long_hold
      wait (hold_armed);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic push_sample(int x, int y, int z);
      sample_t smp;
      smp.x = clamp16(x);
      smp.y = clamp16(y);
      smp.z = clamp16(z);
      sample_q.push_back(smp);
      items_pushed++;
   endtask

   function automatic int jitter(int amp);
      return int'($urandom_range(0, 2 * amp)) - amp;
   endfunction

   function automatic int full_range();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   // mostly held poses with noise and motion spikes, some raw noise bursts
   task automatic push_random_samples(int count);
      int left;
      int len;
      int g;
      int amp;
      int spike;
      int bx;
      int by;
      int bz;
      left = count;
      while (left > 0) begin
         if ($urandom_range(0, 6) == 0) begin
            len = $urandom_range(1, 4);
            repeat (len) push_sample(full_range(), full_range(), full_range());
         end else begin
            g = ($urandom_range(0, 3) == 0) ? $urandom_range(3000, 7000) : G_Q79;
            case ($urandom_range(0, 4))
               0: begin bx = 0;  by = 0;  bz = g;  end   // face up
               1: begin bx = g;  by = 0;  bz = 0;  end   // raised
               2: begin bx = 0;  by = 0;  bz = -g; end   // face down
               3: begin bx = 0;  by = g;  bz = 0;  end   // on its side
               default: begin
                  bx = jitter(g);
                  by = jitter(g);
                  bz = jitter(g);
               end
            endcase
            case ($urandom_range(0, 3))
               0: amp = 0;
               1: amp = 16;
               2: amp = 256;
               default: amp = 2048;
            endcase
            len = $urandom_range(4, 40);
            for (int k = 0; k < len; k++) begin
               spike = ($urandom_range(0, 19) == 0) ? jitter(20000) : 0;
               push_sample(bx + jitter(amp) + spike, by + jitter(amp), bz + jitter(amp));
            end
         end
         left -= len;
      end
   endtask

   function automatic int unsigned pick(int unsigned lo, int unsigned hi,
                                        int unsigned typ_lo, int unsigned typ_hi);
      case ($urandom_range(0, 9))
         0: return lo;
         1: return hi;
         default: return $urandom_range(typ_lo, typ_hi);
      endcase
   endfunction

   function automatic cfg_type make_cfg(int unsigned alpha, int unsigned rr, int unsigned dr,
                                        int unsigned ed, int unsigned ld, int unsigned thr,
                                        int unsigned ad);
      cfg_type c;
      c.lp_alpha           = alpha[15:0];
      c.raised_ratio       = rr[11:0];
      c.dominance_ratio    = dr[11:0];
      c.enter_dwell        = ed[7:0];
      c.leave_dwell        = ld[7:0];
      c.activity_threshold = thr[14:0];
      c.activity_dwell     = ad[9:0];
      return c;
   endfunction

   // one register write; caller lowers valid after the last one
   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_LP_ALPHA:        tracker_cfg.lp_alpha = val;
         CSR_RAISED_RATIO:    tracker_cfg.raised_ratio = val[11:0];
         CSR_DOMINANCE_RATIO: tracker_cfg.dominance_ratio = val[11:0];
         CSR_ENTER_DWELL:     tracker_cfg.enter_dwell = val[7:0];
         CSR_LEAVE_DWELL:     tracker_cfg.leave_dwell = val[7:0];
         CSR_ACT_THRESHOLD:   tracker_cfg.activity_threshold = val[14:0];
         CSR_ACT_DWELL:       tracker_cfg.activity_dwell = val[9:0];
         default: ;
      endcase
   endtask

   task automatic set_config(cfg_type c);
      write_reg(CSR_LP_ALPHA, c.lp_alpha);
      write_reg(CSR_RAISED_RATIO, c.raised_ratio);
      write_reg(CSR_DOMINANCE_RATIO, c.dominance_ratio);
      write_reg(CSR_ENTER_DWELL, c.enter_dwell);
      write_reg(CSR_LEAVE_DWELL, c.leave_dwell);
      write_reg(CSR_ACT_THRESHOLD, c.activity_threshold);
      write_reg(CSR_ACT_DWELL, c.activity_dwell);
      csr_ch.valid <= 1'b0;
      settings_used++;
   endtask

   // wait for every result, then a short pause so the block is idle
   task automatic drain();
      while (results_seen != items_pushed) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // main sequence
   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.accel_x = '0;
      req_ch.accel_y = '0;
      req_ch.accel_z = '0;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = CSR_LP_ALPHA;
      csr_ch.data    = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: seed, field extremes, then settled poses at reset settings
      push_sample(0, 0, G_Q79);
      push_sample(32767, 32767, 32767);
      push_sample(-32768, -32768, -32768);
      push_sample(0, 0, 0);
      push_sample(-1, -1, -1);
      push_sample(32767, -32768, 0);
      push_sample(-32768, 32767, 1);
      repeat (10) push_sample(0, 0, G_Q79);
      repeat (8) push_sample(G_Q79, 0, 0);
      drain();
      settings_used++;

      // fast filter, short dwells
      set_config(make_cfg(32768, 256, 384, 3, 6, 600, 20));
      push_random_samples(150);
      drain();

      // frozen filter, zero dwells, zero threshold, ratio extremes
      set_config(make_cfg(0, 0, 4095, 0, 0, 0, 1023));
      push_random_samples(60);
      drain();

      // enter dwell above leave dwell: raised/flat can never commit
      set_config(make_cfg(65535, 4095, 0, 200, 5, 32767, 0));
      push_random_samples(100);
      drain();

      // receiver holds off while samples keep coming
      set_config(make_cfg(16384, 300, 300, 4, 12, 800, 30));
      hold_armed = 1'b1;
      push_random_samples(60);
      drain();

      // build up the quiet count, then lower its cap below it
      set_config(make_cfg(8192, 256, 384, 2, 4, 32767, 1023));
      repeat (40) push_sample(0, 0, G_Q79);
      drain();
      write_reg(CSR_ACT_DWELL, 16'd5);
      write_reg(CSR_ACT_THRESHOLD, 16'd64);
      csr_ch.valid <= 1'b0;
      settings_used++;
      repeat (5) push_sample(0, 0, G_Q79);
      push_random_samples(35);
      drain();

      // random settings; the last phase runs without idling
      for (int p = 0; p < 6; p++) begin
         if (p == 5) idle_on <= 1'b0;
         set_config(make_cfg(pick(1, 65535, 512, 40000), pick(0, 4095, 128, 640),
                             pick(0, 4095, 128, 640), pick(0, 255, 1, 10),
                             pick(0, 255, 1, 24), pick(0, 32767, 64, 3000),
                             pick(0, 1023, 0, 60)));
         push_random_samples(150);
         drain();
      end

      repeat (30) @(posedge clock);
      if (predicted_track_q.size() != 0) begin
         errors += predicted_track_q.size();
         $display("%0t: %0d predicted results never arrived, expected 0 left, actual %0d",
                  $time, predicted_track_q.size(), predicted_track_q.size());
      end
      $display("Covered %0d samples over %0d register settings: %0d orientation commits, %0d motion samples.",
               results_seen, settings_used, commit_count, motion_count);
      $display("Included a %0d-cycle result hold-off with samples still offered.",
               LONG_HOLD_CYCLES);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/gotr_pkg.sv
hdl/gotr_req_if.sv
hdl/gotr_rsp_if.sv
hdl/gotr_csr_if.sv
hdl/gotr_cfg.sv
hdl/gotr_mul.sv
hdl/gravity_orientation_tracker_unit.sv
dv/tb_gravity_orientation_tracker_unit.sv
